// ===== design/baro_temp_pressure_compensation_defines.svh =====
// ----------------------------------------------------------------------------
// Barometer compensation assertion macros
// Shared concurrent assertion forms used at the top level.
// ----------------------------------------------------------------------------
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_DEFINES_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BTPC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("btpc assertion failed");

// Next-cycle implication, checked outside reset.
`define BTPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("btpc assertion failed");

`endif

// ===== design/btpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Barometer compensation package
// Shared types, register indexes and wrapping multiply helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package btpc_pkg;

  typedef logic signed [63:0] s64_t;

  typedef enum logic [2:0] {
    REG_TEMP_CAL_ONE   = 3'd0,
    REG_TEMP_CAL_TWO   = 3'd1,
    REG_TEMP_CAL_THREE = 3'd2,
    REG_PRES_CAL_LOW   = 3'd3,
    REG_PRES_CAL_HIGH  = 3'd4,
    REG_PRES_CAL_NINE  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [19:0] raw_pressure;
    logic [19:0] raw_temperature;
  } item_t;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] c1;
    logic [15:0] c2;
    logic [15:0] c3;
    logic [15:0] c4;
    logic [15:0] c5;
    logic [15:0] c6;
    logic [15:0] c7;
    logic [15:0] c8;
    logic [15:0] c9;
  } cal_t;

  typedef struct packed {
    logic signed [31:0] temp;
    logic [19:0]        raw_pressure;
  } side_t;

  // Partial products of a 64-bit product taken modulo 2^64.
  typedef struct packed {
    logic [63:0] lo;
    logic [31:0] mid;
  } pp_t;

  function automatic pp_t mul_pp(input logic [63:0] a, input logic [63:0] b);
    pp_t r;
    r.lo  = {32'b0, a[31:0]} * {32'b0, b[31:0]};
    r.mid = a[31:0] * b[63:32] + a[63:32] * b[31:0];
    return r;
  endfunction

  function automatic logic [63:0] mul_sum(input pp_t p);
    return p.lo + {p.mid, 32'b0};
  endfunction

  function automatic s64_t sx16(input logic [15:0] w);
    return {{48{w[15]}}, w};
  endfunction

  function automatic s64_t ux16(input logic [15:0] w);
    return {48'b0, w};
  endfunction

endpackage

`default_nettype wire

// ===== design/btpc_front.sv =====
// ----------------------------------------------------------------------------
// Barometer compensation front end
// Accepts start transfers into a two-entry queue feeding the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module btpc_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire logic [19:0]     raw_pressure,
  input  wire logic [19:0]     raw_temperature,
  output logic                 out_vld,
  output btpc_pkg::item_t      out_item
);
  import btpc_pkg::*;

  item_t      q [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       push;
  logic       pop;

  assign busy     = (cnt == 2'd2);
  assign push     = start && !busy;
  assign pop      = (cnt != 2'd0);
  assign out_vld  = pop;
  assign out_item = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{raw_pressure: raw_pressure, raw_temperature: raw_temperature};
    end
  end

endmodule

`default_nettype wire

// ===== design/btpc_temp.sv =====
// ----------------------------------------------------------------------------
// Barometer compensation temperature stages
// Computes the fine temperature and the saturated temperature in eight stages.
// ----------------------------------------------------------------------------
`default_nettype none

module btpc_temp (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_vld,
  input  wire btpc_pkg::item_t in_item,
  input  wire btpc_pkg::cal_t  cal,
  output logic                 out_vld,
  output btpc_pkg::s64_t       out_x,
  output btpc_pkg::side_t      out_side
);
  import btpc_pkg::*;

  logic [7:0]  vld;
  logic [19:0] p_line [0:7];
  s64_t        a0, b0, da3, bb3, da4, da5, db5, fine6, x7, t57, x8, tsh;
  pp_t         pa2, pb2, pc4;
  logic signed [31:0] temp8;

  assign tsh      = (t57 + 64'sd128) >>> 8;
  assign out_vld  = vld[7];
  assign out_x    = x8;
  assign out_side = '{temp: temp8, raw_pressure: p_line[7]};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 8'b0;
    end else begin
      vld <= {vld[6:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    p_line[0] <= in_item.raw_pressure;
    for (int i = 1; i < 8; i++) begin
      p_line[i] <= p_line[i-1];
    end
    a0    <= {47'b0, in_item.raw_temperature[19:3]} - {47'b0, cal.t1, 1'b0};
    b0    <= {48'b0, in_item.raw_temperature[19:4]} - {48'b0, cal.t1};
    pa2   <= mul_pp(a0, sx16(cal.t2));
    pb2   <= mul_pp(b0, b0);
    da3   <= $signed(mul_sum(pa2)) >>> 11;
    bb3   <= $signed(mul_sum(pb2)) >>> 12;
    da4   <= da3;
    pc4   <= mul_pp(bb3, sx16(cal.t3));
    da5   <= da4;
    db5   <= $signed(mul_sum(pc4)) >>> 14;
    fine6 <= da5 + db5;
    x7    <= fine6 - 64'sd128000;
    t57   <= fine6 + (fine6 <<< 2);
    x8    <= x7;
    if (tsh > 64'sd2147483647) begin
      temp8 <= 32'sh7fffffff;
    end else if (tsh < -64'sd2147483648) begin
      temp8 <= 32'sh80000000;
    end else begin
      temp8 <= tsh[31:0];
    end
  end

endmodule

`default_nettype wire

// ===== design/btpc_ppre.sv =====
// ----------------------------------------------------------------------------
// Barometer compensation pressure pre-stages
// Builds the dividend and divisor of the pressure division in eight stages.
// ----------------------------------------------------------------------------
`default_nettype none

module btpc_ppre (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_vld,
  input  wire btpc_pkg::s64_t  in_x,
  input  wire btpc_pkg::side_t in_side,
  input  wire btpc_pkg::cal_t  cal,
  output logic                 out_vld,
  output btpc_pkg::s64_t       out_num,
  output btpc_pkg::s64_t       out_den,
  output btpc_pkg::side_t      out_side
);
  import btpc_pkg::*;

  logic [7:0]  vld;
  side_t       sd [0:7];
  pp_t         pxx1, pxc51, pxc21, pya3, pxa3, ppx7, ppq7;
  s64_t        xx2, xc52, xc22, y13, xc2s3, ya4, xa4, y14, xc2s4, y5, xb5;
  s64_t        xd6, q06, num8, den8;
  logic [20:0] qd;

  assign qd       = 21'h100000 - {1'b0, sd[4].raw_pressure};
  assign out_vld  = vld[7];
  assign out_num  = num8;
  assign out_den  = den8;
  assign out_side = sd[7];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 8'b0;
    end else begin
      vld <= {vld[6:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    sd[0] <= in_side;
    for (int i = 1; i < 8; i++) begin
      sd[i] <= sd[i-1];
    end
    pxx1  <= mul_pp(in_x, in_x);
    pxc51 <= mul_pp(in_x, sx16(cal.c5));
    pxc21 <= mul_pp(in_x, sx16(cal.c2));
    xx2   <= mul_sum(pxx1);
    xc52  <= mul_sum(pxc51);
    xc22  <= mul_sum(pxc21);
    pya3  <= mul_pp(xx2, sx16(cal.c6));
    pxa3  <= mul_pp(xx2, sx16(cal.c3));
    y13   <= (xc52 <<< 17) + (sx16(cal.c4) <<< 35);
    xc2s3 <= xc22 <<< 12;
    ya4   <= mul_sum(pya3);
    xa4   <= mul_sum(pxa3);
    y14   <= y13;
    xc2s4 <= xc2s3;
    y5    <= ya4 + y14;
    xb5   <= (xa4 >>> 8) + xc2s4;
    xd6   <= 64'sh0000_8000_0000_0000 + xb5;
    q06   <= ({43'b0, qd} << 31) - y5;
    ppx7  <= mul_pp(xd6, ux16(cal.c1));
    ppq7  <= mul_pp(q06, 64'd3125);
    den8  <= $signed(mul_sum(ppx7)) >>> 33;
    num8  <= mul_sum(ppq7);
  end

endmodule

`default_nettype wire

// ===== design/btpc_div.sv =====
// ----------------------------------------------------------------------------
// Barometer compensation divider
// Pipelined signed 64-bit division, one quotient bit per stage, truncating.
// ----------------------------------------------------------------------------
`default_nettype none

module btpc_div (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_vld,
  input  wire btpc_pkg::s64_t  in_num,
  input  wire btpc_pkg::s64_t  in_den,
  input  wire btpc_pkg::side_t in_side,
  output logic                 out_vld,
  output btpc_pkg::s64_t       out_q,
  output logic                 out_nz,
  output btpc_pkg::side_t      out_side
);
  import btpc_pkg::*;

  logic [64:0] vld;
  logic [63:0] rem [0:64];
  logic [63:0] nq  [0:64];
  logic [63:0] dm  [0:64];
  logic        neg [0:64];
  logic        nz  [0:64];
  side_t       sd  [0:64];
  logic        vld_q;
  s64_t        q_r;
  logic        nz_r;
  side_t       sd_r;

  assign out_vld  = vld_q;
  assign out_q    = q_r;
  assign out_nz   = nz_r;
  assign out_side = sd_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      vld   <= {vld[63:0], in_vld};
      vld_q <= vld[64];
    end
  end

  always_ff @(posedge clk) begin
    rem[0] <= 64'd0;
    nq[0]  <= in_num[63] ? 64'd0 - in_num : in_num;
    dm[0]  <= in_den[63] ? 64'd0 - in_den : in_den;
    neg[0] <= in_num[63] ^ in_den[63];
    nz[0]  <= (in_den != 64'sd0);
    sd[0]  <= in_side;
    q_r    <= neg[64] ? 64'd0 - nq[64] : nq[64];
    nz_r   <= nz[64];
    sd_r   <= sd[64];
  end

  for (genvar i = 0; i < 64; i++) begin : g_step
    logic [63:0] rsh;
    logic        ge;
    assign rsh = {rem[i][62:0], nq[i][63]};
    assign ge  = (rsh >= dm[i]);
    always_ff @(posedge clk) begin
      rem[i+1] <= ge ? rsh - dm[i] : rsh;
      nq[i+1]  <= {nq[i][62:0], ge};
      dm[i+1]  <= dm[i];
      neg[i+1] <= neg[i];
      nz[i+1]  <= nz[i];
      sd[i+1]  <= sd[i];
    end
  end

endmodule

`default_nettype wire

// ===== design/btpc_ppost.sv =====
// ----------------------------------------------------------------------------
// Barometer compensation pressure post-stages
// Applies the quotient corrections, clamps and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module btpc_ppost (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_vld,
  input  wire btpc_pkg::s64_t  in_q,
  input  wire logic            in_nz,
  input  wire btpc_pkg::side_t in_side,
  input  wire btpc_pkg::cal_t  cal,
  output logic                 done,
  output logic signed [31:0]   temperature_centi,
  output logic [31:0]          pressure_q24_8,
  output logic                 pressure_valid
);
  import btpc_pkg::*;

  logic [7:0]         vld;
  logic signed [31:0] tl [0:7];
  logic               nzl [0:7];
  s64_t               q1, qs1, q2, qs2, db2, m3, qs3, q3, db3, q4, db4;
  s64_t               da5, q5, db5, s6, db6, s7, pr8;
  pp_t                ppa1, ppb2, ppc4;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= 8'b0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[6:0], in_vld};
      done <= vld[7];
    end
  end

  always_ff @(posedge clk) begin
    tl[0]  <= in_side.temp;
    nzl[0] <= in_nz;
    for (int i = 1; i < 8; i++) begin
      tl[i]  <= tl[i-1];
      nzl[i] <= nzl[i-1];
    end
    q1   <= in_q;
    qs1  <= in_q >>> 13;
    ppa1 <= mul_pp(sx16(cal.c8), in_q);
    q2   <= q1;
    qs2  <= qs1;
    ppb2 <= mul_pp(sx16(cal.c9), qs1);
    db2  <= $signed(mul_sum(ppa1)) >>> 19;
    m3   <= mul_sum(ppb2);
    qs3  <= qs2;
    q3   <= q2;
    db3  <= db2;
    ppc4 <= mul_pp(m3, qs3);
    q4   <= q3;
    db4  <= db3;
    da5  <= $signed(mul_sum(ppc4)) >>> 25;
    q5   <= q4;
    db5  <= db4;
    s6   <= q5 + da5;
    db6  <= db5;
    s7   <= s6 + db6;
    pr8  <= (s7 >>> 8) + (sx16(cal.c7) <<< 4);
    temperature_centi <= tl[7];
    pressure_valid    <= nzl[7];
    if (!nzl[7] || pr8[63]) begin
      pressure_q24_8 <= 32'd0;
    end else if (pr8[63:32] != 32'd0) begin
      pressure_q24_8 <= 32'hffffffff;
    end else begin
      pressure_q24_8 <= pr8[31:0];
    end
  end

endmodule

`default_nettype wire

// ===== design/baro_temp_pressure_compensation.sv =====
// ----------------------------------------------------------------------------
// Barometer temperature and pressure compensation
// Integer compensation of raw 20-bit readings with programmable calibration.
// ----------------------------------------------------------------------------
// A new reading may be started in every clock cycle; busy stays low in normal
// use. Each result appears on done after the front queue, temperature stages,
// pressure pre-stages, pipelined divider and post-stages, in the order the
// readings arrived. The result must be taken in the cycle done is high. The
// user must write calibration registers only while no reading is in flight;
// the block itself does not enforce this.
`default_nettype none

module baro_temp_pressure_compensation (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire logic [19:0]   raw_pressure,
  input  wire logic [19:0]   raw_temperature,
  input  wire logic          wr_en,
  input  wire logic [2:0]    wr_index,
  input  wire logic [63:0]   wr_data,
  output logic               done,
  output logic signed [31:0] temperature_centi,
  output logic [31:0]        pressure_q24_8,
  output logic               pressure_valid
);
  import btpc_pkg::*;
  `include "baro_temp_pressure_compensation_defines.svh"

  logic [15:0] temp_cal_one;
  logic [15:0] temp_cal_two;
  logic [15:0] temp_cal_three;
  logic [63:0] pres_cal_low_pack;
  logic [63:0] pres_cal_high_pack;
  logic [15:0] pres_cal_nine;
  cal_t        cal;

  logic        f_vld;
  item_t       f_item;
  logic        t_vld;
  s64_t        t_x;
  side_t       t_side;
  logic        p_vld;
  s64_t        p_num;
  s64_t        p_den;
  side_t       p_side;
  logic        d_vld;
  s64_t        d_q;
  logic        d_nz;
  side_t       d_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_cal_one       <= 16'd0;
      temp_cal_two       <= 16'd0;
      temp_cal_three     <= 16'd0;
      pres_cal_low_pack  <= 64'd0;
      pres_cal_high_pack <= 64'd0;
      pres_cal_nine      <= 16'd0;
    end else if (wr_en) begin
      case (wr_index)
        REG_TEMP_CAL_ONE:   temp_cal_one       <= wr_data[15:0];
        REG_TEMP_CAL_TWO:   temp_cal_two       <= wr_data[15:0];
        REG_TEMP_CAL_THREE: temp_cal_three     <= wr_data[15:0];
        REG_PRES_CAL_LOW:   pres_cal_low_pack  <= wr_data;
        REG_PRES_CAL_HIGH:  pres_cal_high_pack <= wr_data;
        REG_PRES_CAL_NINE:  pres_cal_nine      <= wr_data[15:0];
        default: begin
        end
      endcase
    end
  end

  assign cal = '{
    t1: temp_cal_one, t2: temp_cal_two, t3: temp_cal_three,
    c1: pres_cal_low_pack[15:0],  c2: pres_cal_low_pack[31:16],
    c3: pres_cal_low_pack[47:32], c4: pres_cal_low_pack[63:48],
    c5: pres_cal_high_pack[15:0],  c6: pres_cal_high_pack[31:16],
    c7: pres_cal_high_pack[47:32], c8: pres_cal_high_pack[63:48],
    c9: pres_cal_nine
  };

  btpc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .raw_pressure    (raw_pressure),
    .raw_temperature (raw_temperature),
    .out_vld         (f_vld),
    .out_item        (f_item)
  );

  btpc_temp u_temp (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (f_vld),
    .in_item  (f_item),
    .cal      (cal),
    .out_vld  (t_vld),
    .out_x    (t_x),
    .out_side (t_side)
  );

  btpc_ppre u_ppre (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (t_vld),
    .in_x     (t_x),
    .in_side  (t_side),
    .cal      (cal),
    .out_vld  (p_vld),
    .out_num  (p_num),
    .out_den  (p_den),
    .out_side (p_side)
  );

  btpc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (p_vld),
    .in_num   (p_num),
    .in_den   (p_den),
    .in_side  (p_side),
    .out_vld  (d_vld),
    .out_q    (d_q),
    .out_nz   (d_nz),
    .out_side (d_side)
  );

  btpc_ppost u_ppost (
    .clk               (clk),
    .rst               (rst),
    .in_vld            (d_vld),
    .in_q              (d_q),
    .in_nz             (d_nz),
    .in_side           (d_side),
    .cal               (cal),
    .done              (done),
    .temperature_centi (temperature_centi),
    .pressure_q24_8    (pressure_q24_8),
    .pressure_valid    (pressure_valid)
  );

  `BTPC_ASSERT_SAME(a_invalid_zero, done && !pressure_valid, pressure_q24_8 == 32'd0)
  `BTPC_ASSERT_NEXT(a_never_full, start && !busy, !busy)
  `BTPC_ASSERT_SAME(a_no_done_after_reset, $past(rst), !done)

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// Barometer compensation testbench
// Drives raw readings through several calibration sets, predicts every result
// in 64-bit wrapping integer arithmetic and checks each one as it leaves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import btpc_pkg::*;

  localparam logic [2:0] UNUSED_INDEX_A = 3'd6;
  localparam logic [2:0] UNUSED_INDEX_B = 3'd7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 120;

  typedef struct {
    logic signed [31:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
    logic               pressure_valid;
  } reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [19:0] raw_pressure = '0;
  logic [19:0] raw_temperature = '0;
  logic wr_en = 1'b0;
  logic [2:0] wr_index = '0;
  logic [63:0] wr_data = '0;
  logic done;
  logic signed [31:0] temperature_centi;
  logic [31:0] pressure_q24_8;
  logic pressure_valid;

  logic [15:0] cal_t1, cal_t2, cal_t3, cal_c9;
  logic [63:0] cal_low, cal_high;
  reading_t expected_readings[$];
  int fails = 0;
  int cycles = 0;
  bit steady = 1'b0;

  baro_temp_pressure_compensation dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .raw_pressure(raw_pressure), .raw_temperature(raw_temperature),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .done(done), .temperature_centi(temperature_centi),
    .pressure_q24_8(pressure_q24_8), .pressure_valid(pressure_valid)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  function automatic reading_t compensate(input logic [19:0] rp, input logic [19:0] rt);
    reading_t r;
    s64_t adc_p, adc_t, t1, t2, t3, c1, c2, c3, c4, c5, c6, c7, c8, c9;
    s64_t da, db, fine, temp, x, y, q, n, pres;
    adc_p = ux16(16'h0) + {44'b0, rp};
    adc_t = {44'b0, rt};
    t1 = {48'b0, cal_t1};
    t2 = {{48{cal_t2[15]}}, cal_t2};
    t3 = {{48{cal_t3[15]}}, cal_t3};
    c1 = {48'b0, cal_low[15:0]};
    c2 = {{48{cal_low[31]}}, cal_low[31:16]};
    c3 = {{48{cal_low[47]}}, cal_low[47:32]};
    c4 = {{48{cal_low[63]}}, cal_low[63:48]};
    c5 = {{48{cal_high[15]}}, cal_high[15:0]};
    c6 = {{48{cal_high[31]}}, cal_high[31:16]};
    c7 = {{48{cal_high[47]}}, cal_high[47:32]};
    c8 = {{48{cal_high[63]}}, cal_high[63:48]};
    c9 = {{48{cal_c9[15]}}, cal_c9};
    da = (((adc_t >>> 3) - (t1 <<< 1)) * t2) >>> 11;
    db = (adc_t >>> 4) - t1;
    db = (((db * db) >>> 12) * t3) >>> 14;
    fine = da + db;
    temp = (fine * 64'sd5 + 64'sd128) >>> 8;
    if (temp > 64'sd2147483647) temp = 64'sd2147483647;
    if (temp < -64'sd2147483648) temp = -64'sd2147483648;
    r.temperature_centi = temp[31:0];
    x = fine - 64'sd128000;
    y = (x * x) * c6;
    y = y + ((x * c5) <<< 17);
    y = y + (c4 <<< 35);
    x = (((x * x) * c3) >>> 8) + ((x * c2) <<< 12);
    x = (((64'sd1 <<< 47) + x) * c1) >>> 33;
    r.pressure_q24_8 = '0;
    r.pressure_valid = 1'b0;
    if (x != 0) begin
      q = 64'sd1048576 - adc_p;
      n = ((q <<< 31) - y) * 64'sd3125;
      q = (x == -64'sd1) ? -n : n / x;
      da = ((c9 * (q >>> 13)) * (q >>> 13)) >>> 25;
      db = (c8 * q) >>> 19;
      pres = ((q + da + db) >>> 8) + (c7 <<< 4);
      if (pres < 0) r.pressure_q24_8 = '0;
      else if (pres > 64'sh0_FFFF_FFFF) r.pressure_q24_8 = 32'hFFFF_FFFF;
      else r.pressure_q24_8 = pres[31:0];
      r.pressure_valid = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    reading_t e;
    if (!rst && done) begin
      if (expected_readings.size() == 0) begin
        $error("result transfer with no reading outstanding");
        fails++;
      end else begin
        e = expected_readings.pop_front();
        if (temperature_centi !== e.temperature_centi) begin
          $error("temperature_centi expected %0d actual %0d", e.temperature_centi,
                 temperature_centi);
          fails++;
        end
        if (pressure_q24_8 !== e.pressure_q24_8) begin
          $error("pressure_q24_8 expected %0d actual %0d", e.pressure_q24_8,
                 pressure_q24_8);
          fails++;
        end
        if (pressure_valid !== e.pressure_valid) begin
          $error("pressure_valid expected %0d actual %0d", e.pressure_valid,
                 pressure_valid);
          fails++;
        end
      end
    end
  end

  task automatic send_reading(input logic [19:0] rp, input logic [19:0] rt);
    while (!steady && $urandom_range(99) < 28) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    raw_pressure <= rp;
    raw_temperature <= rt;
    do @(posedge clk); while (busy);
    expected_readings.push_back(compensate(rp, rt));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(posedge clk);
    case (idx)
      REG_TEMP_CAL_ONE:   cal_t1 = data[15:0];
      REG_TEMP_CAL_TWO:   cal_t2 = data[15:0];
      REG_TEMP_CAL_THREE: cal_t3 = data[15:0];
      REG_PRES_CAL_LOW:   cal_low = data;
      REG_PRES_CAL_HIGH:  cal_high = data;
      REG_PRES_CAL_NINE:  cal_c9 = data[15:0];
      default: ;
    endcase
  endtask

  task automatic load_calibration(input logic [15:0] t1, input logic [15:0] t2,
                                  input logic [15:0] t3, input logic [63:0] lo,
                                  input logic [63:0] hi, input logic [15:0] c9);
    drain();
    write_reg(REG_TEMP_CAL_ONE, {$urandom, 16'($urandom_range(65535)), t1});
    write_reg(REG_TEMP_CAL_TWO, {48'b0, t2});
    write_reg(REG_TEMP_CAL_THREE, {48'b0, t3});
    write_reg(REG_PRES_CAL_LOW, lo);
    write_reg(REG_PRES_CAL_HIGH, hi);
    write_reg(REG_PRES_CAL_NINE, {$urandom, 16'hFFFF, c9});
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_typical();
    load_calibration(16'd27504, 16'd26435, -16'sd1000,
                     {16'd2855, 16'd3024, -16'sd10685, 16'd36477},
                     {-16'sd14600, 16'd15500, -16'sd7, 16'd140}, 16'd6000);
  endtask

  task automatic test_reset_calibration();
    send_reading(20'd0, 20'd0);
    send_reading(20'hFFFFF, 20'hFFFFF);
  endtask

  task automatic test_directed();
    load_typical();
    send_reading(20'd415148, 20'd519888);
    send_reading(20'd0, 20'd0);
    send_reading(20'hFFFFF, 20'hFFFFF);
    send_reading(20'hFFFFF, 20'd0);
    send_reading(20'd0, 20'hFFFFF);
    send_reading(20'h80000, 20'h80000);
    drain();
    write_reg(UNUSED_INDEX_A, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(UNUSED_INDEX_B, 64'h0);
    wr_en <= 1'b0;
    @(posedge clk);
    send_reading(20'd415148, 20'd519888);
    // A zero first pressure word makes the divisor zero.
    load_calibration(16'd27504, 16'd26435, -16'sd1000, 64'h0B27_0BD0_D643_0000,
                     64'hC6F8_3C8C_FFF9_008C, 16'd6000);
    send_reading(20'd415148, 20'd519888);
    send_reading(20'hFFFFF, 20'hFFFFF);
    load_calibration(16'hFFFF, 16'h7FFF, 16'h7FFF, 64'hFFFF_FFFF_FFFF_FFFF,
                     64'h7FFF_7FFF_7FFF_7FFF, 16'h7FFF);
    send_reading(20'd0, 20'd0);
    send_reading(20'hFFFFF, 20'hFFFFF);
    send_reading(20'd0, 20'hFFFFF);
    load_calibration(16'h0, 16'h8000, 16'h8000, 64'h8000_8000_8000_FFFF,
                     64'h8000_8000_8000_8000, 16'h8000);
    send_reading(20'd0, 20'd0);
    send_reading(20'hFFFFF, 20'hFFFFF);
    send_reading(20'hFFFFF, 20'd0);
  endtask

  task automatic random_readings(input int count, input bit near_typical);
    for (int i = 0; i < count; i++) begin
      if (near_typical && $urandom_range(3) != 0)
        send_reading(20'($urandom_range(300000, 600000)),
                     20'($urandom_range(400000, 650000)));
      else
        send_reading(20'($urandom), 20'($urandom));
    end
  endtask

  task automatic test_random();
    load_typical();
    random_readings(150, 1'b1);
    steady = 1'b1;
    random_readings(100, 1'b1);
    steady = 1'b0;
    drain();
    random_readings(50, 1'b1);
    for (int p = 0; p < 8; p++) begin
      if (p % 2 == 0)
        load_calibration(16'($urandom_range(26000, 29000)),
                         16'($urandom_range(25000, 27000)),
                         -16'($urandom_range(500, 1500)),
                         {16'($urandom_range(2000, 4000)), 16'($urandom_range(2000, 4000)),
                          -16'($urandom_range(9000, 12000)),
                          16'($urandom_range(34000, 38000))},
                         {-16'($urandom_range(13000, 16000)),
                          16'($urandom_range(14000, 17000)), -16'($urandom_range(20)),
                          16'($urandom_range(100, 200))},
                         16'($urandom_range(4000, 8000)));
      else
        load_calibration(16'($urandom), 16'($urandom), 16'($urandom),
                         {$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom));
      random_readings(50, p % 2 == 0);
    end
  endtask

  initial begin
    cal_t1 = '0; cal_t2 = '0; cal_t3 = '0; cal_c9 = '0;
    cal_low = '0; cal_high = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_calibration();
    test_directed();
    test_random();
    drain();
    if (fails == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+design
design/btpc_pkg.sv
design/btpc_front.sv
design/btpc_temp.sv
design/btpc_ppre.sv
design/btpc_div.sv
design/btpc_ppost.sv
design/baro_temp_pressure_compensation.sv
bench/testbench.sv
